// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define SDR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define SDR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/sdr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdr_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Probe travelling down the cell chain
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic             hit;     // matched a stored value upstream
    logic             placed;  // stored in an empty cell upstream
    logic [CNT_W-1:0] rem;     // occupied cells still ahead of this point
  } sdr_tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_WAIT
  } sdr_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/stream_duplicate_remover.sv =====
// Path: the probe is registered in each of the TABLE_DEPTH cells (64 by default),
// then in the output register, before out_tvalid. One item at a time: the probe walks
// the comparator chain cell by cell; the next item enters after it leaves and its result reaches the output register.
// Reset: synchronous active-low rst_n empties the table and clears the pipeline;
// stored values are not cleared, the fill count masks them.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module stream_duplicate_remover (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] element
  input  wire logic        in_tuser,   // [0] start_new
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] out_value
  output logic [1:0]       out_tuser   // [0] kept, [1] table_full
);

  localparam int unsigned DEPTH = sdr_pkg::TABLE_DEPTH;

  sdr_pkg::sdr_state_t       state_r, state_nxt;
  logic [sdr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [31:0]               out_data_r, out_data_nxt;
  logic [1:0]                out_user_r, out_user_nxt;
  logic [31:0]               pend_data_r, pend_data_nxt;
  logic [1:0]                pend_user_r, pend_user_nxt;

  sdr_pkg::sdr_tok_t tok [DEPTH+1];
  sdr_pkg::sdr_tok_t exit_tok;
  logic [DEPTH-1:0]  chain_busy;

  logic       accept;
  logic       out_free;
  logic       is_wait;
  logic [1:0] exit_user;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign exit_tok = tok[DEPTH];
  assign exit_user = {!exit_tok.hit && !exit_tok.placed, exit_tok.placed};

  // Probe injection; a new array starts with no occupied cells
  always_comb begin
    tok[0].valid  = accept;
    tok[0].value  = in_tdata;
    tok[0].hit    = 1'b0;
    tok[0].placed = 1'b0;
    tok[0].rem    = in_tuser ? '0 : cnt_r;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sdr_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
    assign chain_busy[i] = tok[i+1].valid;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdr_pkg::ST_IDLE: if (in_tvalid) state_nxt = sdr_pkg::ST_BUSY;
      sdr_pkg::ST_BUSY: begin
        if (exit_tok.valid) state_nxt = out_free ? sdr_pkg::ST_IDLE : sdr_pkg::ST_WAIT;
      end
      sdr_pkg::ST_WAIT: if (out_free) state_nxt = sdr_pkg::ST_IDLE;
      default:          state_nxt = sdr_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_tready = 1'b0;
    is_wait   = 1'b0;
    unique case (state_r)
      sdr_pkg::ST_IDLE: in_tready = 1'b1;
      sdr_pkg::ST_BUSY: ;
      sdr_pkg::ST_WAIT: is_wait = 1'b1;
      default:          ;
    endcase
  end

  // Fill count and result path
  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    pend_data_nxt = pend_data_r;
    pend_user_nxt = pend_user_r;

    if (accept && in_tuser) begin
      cnt_nxt = '0;
    end else if (exit_tok.valid && exit_tok.placed) begin
      cnt_nxt = cnt_r + sdr_pkg::CNT_W'(1);
    end

    if (exit_tok.valid) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = exit_tok.value;
        out_user_nxt  = exit_user;
      end else begin
        pend_data_nxt = exit_tok.value;
        pend_user_nxt = exit_user;
      end
    end else if (is_wait && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pend_data_r;
      out_user_nxt  = pend_user_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdr_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
    pend_data_r <= pend_data_nxt;
    pend_user_r <= pend_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `SDR_ASSERT(a_cnt_bound, cnt_r <= sdr_pkg::CNT_W'(DEPTH), "fill count exceeds table depth")
  `SDR_ASSERT(a_one_probe, $onehot0(chain_busy), "more than one transaction in the chain")
  `SDR_ASSERT(a_exit_busy, exit_tok.valid |-> state_r == sdr_pkg::ST_BUSY, "probe left chain outside busy state")
  `SDR_ASSERT(a_exit_flags, exit_tok.valid |-> !(exit_tok.hit && exit_tok.placed), "repeat value was stored")
  `SDR_ASSERT(a_wait_out, is_wait |-> out_valid_r, "waiting with an empty output register")

endmodule

`default_nettype wire

// ===== rtl/core/sdr_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdr_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sdr_pkg::sdr_tok_t tok_i,
  output sdr_pkg::sdr_tok_t      tok_o
);

  logic [sdr_pkg::VAL_W-1:0] stored_r;
  logic [sdr_pkg::VAL_W-1:0] stored_nxt;
  sdr_pkg::sdr_tok_t         tok_r;
  sdr_pkg::sdr_tok_t         tok_nxt;
  logic                      occupied;
  logic                      wr_en;

  // rem counts down through the occupied prefix; the first cell with
  // rem == 0 is the first free one
  assign occupied = (tok_i.rem != '0);
  assign wr_en    = tok_i.valid && !occupied && !tok_i.hit && !tok_i.placed;

  always_comb begin
    stored_nxt     = wr_en ? tok_i.value : stored_r;
    tok_nxt        = tok_i;
    tok_nxt.hit    = tok_i.hit || (occupied && (stored_r == tok_i.value));
    tok_nxt.placed = tok_i.placed || wr_en;
    tok_nxt.rem    = occupied ? (tok_i.rem - sdr_pkg::CNT_W'(1)) : tok_i.rem;
  end

  always_ff @(posedge clk) begin
    stored_r <= stored_nxt;
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire
